// File: rtl/round_robin_task_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Round-robin task table: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_TABLE_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define RRTT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrtt: assertion failed");

// next-cycle implication
`define RRTT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrtt: assertion failed");

`else

`define RRTT_ASSERT_IMP(name, clk, rst, ante, cons)
`define RRTT_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin task table: package
// Sizes, request and status codes, transaction structs and the
// find-first helper used by the datapath.
// ----------------------------------------------------------------------------
package rrtt_pkg;

   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int ID_BITS   = 16;

   // request codes
   localparam logic [2:0] REQ_SPAWN = 3'd0;
   localparam logic [2:0] REQ_KILL  = 3'd1;
   localparam logic [2:0] REQ_TICK  = 3'd2;
   localparam logic [2:0] REQ_YIELD = 3'd3;
   localparam logic [2:0] REQ_EXIT  = 3'd4;

   // response status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [2:0] STAT_NO_READY  = 3'd3;
   localparam logic [2:0] STAT_NO_RUN    = 3'd4;

   // per-slot task state
   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_READY = 2'd1,
      SLOT_RUN   = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [ID_BITS-1:0] target_id;
   } req_item_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [ID_BITS-1:0]   result_id;
      logic [SLOT_BITS-1:0] result_slot;
      logic                 running_valid;
      logic [SLOT_BITS-1:0] running_slot;
   } rsp_item_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic exec;      // apply it to the table and load the response
   } rrtt_cmd_type;

   // lowest set bit: {found, index}
   function automatic logic [SLOT_BITS:0] first_set(input logic [SLOTS-1:0] vec);
      logic [SLOT_BITS:0] res;
      res = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res = {1'b1, SLOT_BITS'(i)};
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/round_robin_task_table_unit.sv
// A transaction is latched in the capture step; its response is registered in the execute step.
// The capture/execute sequencer takes no new transaction until the last one has executed;
//   a stalled response holds the execute step until the output register frees.
// The slot search, id match and write-back all happen in the execute cycle.
// Reset (synchronous, active high) frees all slots, sets the id counter to 1 and
//   clears the running pointer; no clearing pass.
// ----------------------------------------------------------------------------
// Round-robin task table unit
// Sixteen-slot task table with spawn, kill, round-robin dispatch, yield and
// exit requests; one response per request.
// ----------------------------------------------------------------------------
module round_robin_task_table_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrtt_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrtt_pkg::rsp_item_type rsp_data
);

   rrtt_pkg::rrtt_cmd_type cmd;

   // sequencer
   rrtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // table and response datapath
   rrtt_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/rrtt_dp.sv
// ----------------------------------------------------------------------------
// Round-robin task table: datapath
// Holds the slot table, id counter and running pointer; performs one
// request per exec command and registers the response.
// ----------------------------------------------------------------------------
module rrtt_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  rrtt_pkg::rrtt_cmd_type cmd,
   input  rrtt_pkg::req_item_type req_data,
   output rrtt_pkg::rsp_item_type rsp_data
);

   rrtt_pkg::req_item_type   req_ff;
   logic [rrtt_pkg::ID_BITS-1:0]   slot_id_ff     [rrtt_pkg::SLOTS];
   rrtt_pkg::slot_state_type       slot_status_ff [rrtt_pkg::SLOTS];
   logic [rrtt_pkg::ID_BITS-1:0]   id_counter_ff;
   logic                           run_valid_ff;
   logic [rrtt_pkg::SLOT_BITS-1:0] run_index_ff;
   rrtt_pkg::rsp_item_type         rsp_ff;

   rrtt_pkg::slot_state_type       slot_status_in [rrtt_pkg::SLOTS];
   logic [rrtt_pkg::ID_BITS-1:0]   id_counter_in;
   logic                           run_valid_in;
   logic [rrtt_pkg::SLOT_BITS-1:0] run_index_in;
   rrtt_pkg::rsp_item_type         rsp_in;
   logic                           id_write;

   logic [rrtt_pkg::SLOTS-1:0]     free_vec;
   logic [rrtt_pkg::SLOTS-1:0]     ready_vec;
   logic [rrtt_pkg::SLOTS-1:0]     upper_vec;
   logic [rrtt_pkg::SLOTS-1:0]     match_vec;
   logic [rrtt_pkg::SLOT_BITS:0]   free_hit;
   logic [rrtt_pkg::SLOT_BITS:0]   match_hit;
   logic [rrtt_pkg::SLOT_BITS:0]   upper_hit;
   logic [rrtt_pkg::SLOT_BITS:0]   ready_hit;
   logic [rrtt_pkg::SLOT_BITS:0]   tick_hit;
   logic [rrtt_pkg::SLOT_BITS-1:0] free_idx;
   logic [rrtt_pkg::SLOT_BITS-1:0] match_idx;
   logic [rrtt_pkg::SLOT_BITS-1:0] tick_idx;
   logic                           task_running;

   // per-slot flags for the searches
   always_comb begin
      for (int i = 0; i < rrtt_pkg::SLOTS; i++) begin
         free_vec[i]  = (slot_status_ff[i] == rrtt_pkg::SLOT_FREE);
         ready_vec[i] = (slot_status_ff[i] == rrtt_pkg::SLOT_READY);
         match_vec[i] = (slot_status_ff[i] != rrtt_pkg::SLOT_FREE) &&
                        (slot_id_ff[i] == req_ff.target_id);
         upper_vec[i] = ready_vec[i] && run_valid_ff &&
                        (rrtt_pkg::SLOT_BITS'(i) > run_index_ff);
      end
   end

   // find-first searches; round robin tries the slots above the pointer first
   assign free_hit  = rrtt_pkg::first_set(free_vec);
   assign match_hit = rrtt_pkg::first_set(match_vec);
   assign upper_hit = rrtt_pkg::first_set(upper_vec);
   assign ready_hit = rrtt_pkg::first_set(ready_vec);
   assign tick_hit  = upper_hit[rrtt_pkg::SLOT_BITS] ? upper_hit : ready_hit;

   assign free_idx  = free_hit[rrtt_pkg::SLOT_BITS-1:0];
   assign match_idx = match_hit[rrtt_pkg::SLOT_BITS-1:0];
   assign tick_idx  = tick_hit[rrtt_pkg::SLOT_BITS-1:0];

   assign task_running = run_valid_ff && (slot_status_ff[run_index_ff] == rrtt_pkg::SLOT_RUN);

   // next table state and response
   always_comb begin
      for (int i = 0; i < rrtt_pkg::SLOTS; i++) begin
         slot_status_in[i] = slot_status_ff[i];
      end
      id_counter_in = id_counter_ff;
      run_valid_in  = run_valid_ff;
      run_index_in  = run_index_ff;
      id_write      = 1'b0;
      rsp_in        = '0;

      case (req_ff.req_type)
         rrtt_pkg::REQ_SPAWN: begin
            if (free_hit[rrtt_pkg::SLOT_BITS]) begin
               id_write                 = 1'b1;
               slot_status_in[free_idx] = rrtt_pkg::SLOT_READY;
               rsp_in.result_id         = id_counter_ff;
               rsp_in.result_slot       = free_idx;
               id_counter_in = (id_counter_ff == '1) ? rrtt_pkg::ID_BITS'(1)
                                                     : id_counter_ff + 1'b1;
            end else begin
               rsp_in.status = rrtt_pkg::STAT_FULL;
            end
         end
         rrtt_pkg::REQ_KILL: begin
            if (match_hit[rrtt_pkg::SLOT_BITS]) begin
               slot_status_in[match_idx] = rrtt_pkg::SLOT_FREE;
               rsp_in.result_slot        = match_idx;
            end else begin
               rsp_in.status = rrtt_pkg::STAT_NOT_FOUND;
            end
         end
         rrtt_pkg::REQ_TICK: begin
            if (tick_hit[rrtt_pkg::SLOT_BITS]) begin
               if (task_running) begin
                  slot_status_in[run_index_ff] = rrtt_pkg::SLOT_READY;
               end
               slot_status_in[tick_idx] = rrtt_pkg::SLOT_RUN;
               run_valid_in             = 1'b1;
               run_index_in             = tick_idx;
               rsp_in.result_id         = slot_id_ff[tick_idx];
               rsp_in.result_slot       = tick_idx;
            end else begin
               rsp_in.status = rrtt_pkg::STAT_NO_READY;
            end
         end
         rrtt_pkg::REQ_YIELD: begin
            if (task_running) begin
               slot_status_in[run_index_ff] = rrtt_pkg::SLOT_READY;
               rsp_in.result_slot           = run_index_ff;
            end else begin
               rsp_in.status = rrtt_pkg::STAT_NO_RUN;
            end
         end
         rrtt_pkg::REQ_EXIT: begin
            if (task_running) begin
               slot_status_in[run_index_ff] = rrtt_pkg::SLOT_FREE;
               rsp_in.result_slot           = run_index_ff;
               run_valid_in                 = 1'b0;
            end else begin
               rsp_in.status = rrtt_pkg::STAT_NO_RUN;
            end
         end
         default: begin
            // unused codes leave everything alone
         end
      endcase

      // running view after this step
      rsp_in.running_valid = run_valid_in &&
                             (slot_status_in[run_index_in] == rrtt_pkg::SLOT_RUN);
      rsp_in.running_slot  = rsp_in.running_valid ? run_index_in : '0;
   end

   // control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rrtt_pkg::SLOTS; i++) begin
            slot_status_ff[i] <= rrtt_pkg::SLOT_FREE;
         end
         id_counter_ff <= rrtt_pkg::ID_BITS'(1);
         run_valid_ff  <= 1'b0;
         run_index_ff  <= '0;
      end else if (cmd.exec) begin
         for (int i = 0; i < rrtt_pkg::SLOTS; i++) begin
            slot_status_ff[i] <= slot_status_in[i];
         end
         id_counter_ff <= id_counter_in;
         run_valid_ff  <= run_valid_in;
         run_index_ff  <= run_index_in;
      end
   end

   // payload: request latch, task ids, response register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.exec && id_write) begin
         slot_id_ff[free_idx] <= id_counter_ff;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/rrtt_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin task table: controller
// Two-state sequencer (capture, execute) plus the response valid flag.
// ----------------------------------------------------------------------------
`include "round_robin_task_table_unit_defines.svh"

module rrtt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrtt_pkg::rrtt_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_busy;

   // response register still holds an untaken transaction
   assign out_busy = rsp_valid_ff && rsp_stall;

   // commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = out_busy;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!out_busy) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted transaction always blocks the next cycle
   `RRTT_ASSERT_NXT(a_accept_then_busy, clock, reset, req_valid && !req_stall, req_stall)
   // never overwrite a response that is still waiting
   `RRTT_ASSERT_IMP(a_exec_out_free, clock, reset, cmd.exec, !(rsp_valid_ff && rsp_stall))
   // a new response only comes from an execute step
   `RRTT_ASSERT_IMP(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff), $past(cmd.exec))

endmodule
